// ===== src/gradient_colormap_table_unit_macros.svh =====
// ----------------------------------------------------------------------------
// gradient colormap table assertion macros
// concurrent assertion helpers clocked on clk_i, quiet while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef GRADIENT_COLORMAP_TABLE_UNIT_MACROS_SVH
`define GRADIENT_COLORMAP_TABLE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define GCT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// condition must never be seen at a clock edge out of reset
`define GCT_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define GCT_ASSERT(name, prop, msg)
`define GCT_ASSERT_NEVER(name, cond, msg)
`endif
`endif

// ===== src/gct_pkg.sv =====
// ----------------------------------------------------------------------------
// gct_pkg
// shared types and constants of the gradient colormap table
// ----------------------------------------------------------------------------
package gct_pkg;

  // width of one color channel and of a packed rgb word
  localparam int unsigned CW   = 8;
  localparam int unsigned RGBW = 3 * CW;

  // divider iteration counter, one quotient bit per cycle
  localparam int unsigned CNTW = $clog2(CW);
  localparam logic [CNTW-1:0] ITER_LAST = CNTW'(CW - 1);

  localparam logic [RGBW-1:0] BLACK = '0;
  localparam logic [RGBW-1:0] WHITE = '1;

  typedef enum logic [1:0] {
    REQ_SET    = 2'd0,
    REQ_CLEAR  = 2'd1,
    REQ_BUILD  = 2'd2,
    REQ_LOOKUP = 2'd3
  } req_e;

endpackage

// ===== src/gct_div.sv =====
// ----------------------------------------------------------------------------
// gct_div
// restoring divider, one quotient bit per cycle; quotient known below 2**CW
// ----------------------------------------------------------------------------
`include "gradient_colormap_table_unit_macros.svh"

module gct_div #(
  parameter int unsigned PosW = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [PosW+gct_pkg::CW-1:0] num_i,
  input  logic [PosW-1:0]             den_i,
  output logic                        done_o,
  output logic [gct_pkg::CW-1:0]      quot_o
);

  localparam int unsigned NW = PosW + gct_pkg::CW;

  logic                      run_q;
  logic                      done_q;
  logic [gct_pkg::CNTW-1:0]  cnt_q;
  logic [PosW-1:0]           rem_q;
  logic [PosW-1:0]           rem_d;
  logic [PosW-1:0]           den_q;
  logic [gct_pkg::CW-1:0]    shift_q;
  logic [PosW:0]             trial;
  logic [PosW:0]             diff;
  logic                      fits;

  // shift in the next dividend bit and try to subtract the divisor
  always_comb begin
    trial = {rem_q, shift_q[gct_pkg::CW-1]};
    diff  = trial - {1'b0, den_q};
    fits  = (trial >= {1'b0, den_q});
    rem_d = fits ? diff[PosW-1:0] : trial[PosW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == gct_pkg::ITER_LAST);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == gct_pkg::ITER_LAST) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // quotient bits replace dividend bits as they shift out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q   <= num_i[NW-1:gct_pkg::CW];
      shift_q <= num_i[gct_pkg::CW-1:0];
      den_q   <= den_i;
    end else if (run_q) begin
      rem_q   <= rem_d;
      shift_q <= {shift_q[gct_pkg::CW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = shift_q;

  `GCT_ASSERT_NEVER(a_start_while_run, start_i && run_q, "divider restarted mid-run")

endmodule

// ===== src/gradient_colormap_table_unit.sv =====
// ----------------------------------------------------------------------------
// gradient_colormap_table_unit
// waterfall colormap: control point store, rgb table, build and lookup
//
// command channel: a transaction is taken at a clock edge with start high
// and busy low; req_type_i selects set point, clear points, build table or
// lookup. every transaction returns exactly one result, shown for one cycle
// with result_valid_o high; the receiver cannot stall it.
// set runs S_SET, lookup S_LKRD then S_LKOUT, clear S_CLR at each position.
// build walks all RANGE positions through the point memory read port
// (states S_BRD and S_BCHK for each), runs S_MUL on the shared multiplier
// once per channel for each span, and fills each entry with three 8-step
// divisions on the shared divider plus the table write.
// busy stays high from accept until the result strobe, so no transaction is
// taken before the previous one has finished; a new transaction may be taken
// while the strobe of the previous one is up.
// reset: an init pass over all RANGE positions loads black at 0 and white at the
// last position, then a full build makes the grey ramp; busy is high for
// the whole pass and no result is given for it.
// ----------------------------------------------------------------------------
`include "gradient_colormap_table_unit_macros.svh"

module gradient_colormap_table_unit #(
  parameter int unsigned RANGE = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        req_type_i,
  input  logic signed [15:0] position_i,
  input  logic [7:0]        red_in_i,
  input  logic [7:0]        green_in_i,
  input  logic [7:0]        blue_in_i,
  output logic              result_valid_o,
  output logic [7:0]        red_out_o,
  output logic [7:0]        green_out_o,
  output logic [7:0]        blue_out_o,
  output logic              status_o
);

  localparam int unsigned PW   = $clog2(RANGE);
  localparam int unsigned NW   = PW + gct_pkg::CW;
  localparam int unsigned RGBW = gct_pkg::RGBW;
  localparam logic [PW-1:0] LAST = PW'(RANGE - 1);

  typedef enum logic [12:0] {
    S_INIT  = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_SET   = 13'b0000000000100,
    S_CLR   = 13'b0000000001000,
    S_LKRD  = 13'b0000000010000,
    S_LKOUT = 13'b0000000100000,
    S_BRD   = 13'b0000001000000,
    S_BCHK  = 13'b0000010000000,
    S_MUL   = 13'b0000100000000,
    S_DIVGO = 13'b0001000000000,
    S_DIVWT = 13'b0010000000000,
    S_WR    = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_e;

  function automatic logic [gct_pkg::CW-1:0] chan_sel(input logic [RGBW-1:0] rgb,
                                                      input logic [1:0] idx);
    logic [gct_pkg::CW-1:0] c;
    case (idx)
      2'd0:    c = rgb[23:16];
      2'd1:    c = rgb[15:8];
      default: c = rgb[7:0];
    endcase
    return c;
  endfunction

  // sequencer
  state_e state_q, state_d;
  logic   accept;
  logic   step_next;
  logic   init_build_q;
  logic   have_prev_q;
  logic [PW-1:0] sweep_q;
  logic [PW-1:0] scan_q;

  // captured transaction
  logic [PW-1:0]   pos_q;
  logic            flag_q;
  logic [RGBW-1:0] set_rgb_q;
  logic [PW-1:0]   pos_clamped;
  logic            pos_oor;

  // span datapath
  logic [PW-1:0]           prev_q;
  logic [RGBW-1:0]         prev_col_q;
  logic [PW-1:0]           p2_q;
  logic [RGBW-1:0]         c2_q;
  logic [PW-1:0]           dist_q;
  logic [PW-1:0]           wi_q;
  logic [1:0]              ch_q;
  logic [NW-1:0]           num_q [3];
  logic signed [gct_pkg::CW:0] delta_q [3];
  logic [gct_pkg::CW-1:0]  quot_q [3];
  logic                    last_entry;

  // shared divider
  logic                    div_start;
  logic                    div_done;
  logic [gct_pkg::CW-1:0]  div_quot;

  // memories and their ports
  logic            pres_mem [RANGE];
  logic [RGBW-1:0] pcol_mem [RANGE];
  logic [RGBW-1:0] tab_mem  [RANGE];
  logic            pres_rd_q;
  logic [RGBW-1:0] pcol_rd_q;
  logic [RGBW-1:0] tab_rd_q;
  logic            pres_we;
  logic            col_we;
  logic [PW-1:0]   pw_addr;
  logic            pw_pres;
  logic [RGBW-1:0] pw_col;
  logic            tab_we;
  logic [PW-1:0]   tab_waddr;
  logic [RGBW-1:0] tab_wdata;

  // result register
  logic            res_valid_q, res_valid_d;
  logic [RGBW-1:0] res_rgb_q, res_rgb_d;
  logic            res_status_q, res_status_d;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  // clamp the signed position into the table, flag when it had to move
  always_comb begin
    pos_oor     = 1'b0;
    pos_clamped = position_i[PW-1:0];
    if (position_i[15]) begin
      pos_oor     = 1'b1;
      pos_clamped = '0;
    end else if ($unsigned(position_i) > 16'(RANGE - 1)) begin
      pos_oor     = 1'b1;
      pos_clamped = LAST;
    end
  end

  assign last_entry = (wi_q == (p2_q - PW'(1)));

  // ---------------------------------------------------------------------------
  // sequencer: next state, memory write ports, result
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    step_next    = 1'b0;
    div_start    = 1'b0;
    pres_we      = 1'b0;
    col_we       = 1'b0;
    pw_addr      = sweep_q;
    pw_pres      = 1'b0;
    pw_col       = gct_pkg::BLACK;
    tab_we       = 1'b0;
    tab_waddr    = wi_q;
    tab_wdata    = {quot_q[0], quot_q[1], quot_q[2]};
    res_valid_d  = 1'b0;
    res_rgb_d    = '0;
    res_status_d = 1'b0;
    case (state_q)
      S_INIT: begin
        // reset points: black at the first slot, white at the last
        pres_we = 1'b1;
        col_we  = 1'b1;
        pw_pres = (sweep_q == '0) || (sweep_q == LAST);
        pw_col  = (sweep_q == LAST) ? gct_pkg::WHITE : gct_pkg::BLACK;
        if (sweep_q == LAST) begin
          state_d = S_BRD;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (gct_pkg::req_e'(req_type_i))
            gct_pkg::REQ_SET:    state_d = S_SET;
            gct_pkg::REQ_CLEAR:  state_d = S_CLR;
            gct_pkg::REQ_BUILD:  state_d = S_BRD;
            gct_pkg::REQ_LOOKUP: state_d = S_LKRD;
            default:             state_d = S_LKRD;
          endcase
        end
      end
      S_SET: begin
        pres_we      = 1'b1;
        col_we       = 1'b1;
        pw_addr      = pos_q;
        pw_pres      = 1'b1;
        pw_col       = set_rgb_q;
        res_valid_d  = 1'b1;
        res_status_d = flag_q;
        state_d      = S_IDLE;
      end
      S_CLR: begin
        // presence only, colors stay behind and are rewritten on set
        pres_we = 1'b1;
        if (sweep_q == LAST) begin
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_LKRD: begin
        state_d = S_LKOUT;
      end
      S_LKOUT: begin
        res_valid_d  = 1'b1;
        res_rgb_d    = tab_rd_q;
        res_status_d = flag_q;
        state_d      = S_IDLE;
      end
      S_BRD: begin
        state_d = S_BCHK;
      end
      S_BCHK: begin
        // a present point after an earlier one closes a span
        if (pres_rd_q && have_prev_q) begin
          state_d = S_MUL;
        end else begin
          step_next = 1'b1;
        end
      end
      S_MUL: begin
        if (ch_q == 2'd2) begin
          state_d = S_DIVGO;
        end
      end
      S_DIVGO: begin
        div_start = 1'b1;
        state_d   = S_DIVWT;
      end
      S_DIVWT: begin
        if (div_done) begin
          state_d = (ch_q == 2'd2) ? S_WR : S_DIVGO;
        end
      end
      S_WR: begin
        tab_we = 1'b1;
        if (last_entry) begin
          step_next = 1'b1;
        end else begin
          state_d = S_DIVGO;
        end
      end
      S_FIN: begin
        // the last point goes in unblended
        if (have_prev_q) begin
          tab_we    = 1'b1;
          tab_waddr = prev_q;
          tab_wdata = prev_col_q;
        end
        res_valid_d = !init_build_q;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (step_next) begin
      state_d = (scan_q == LAST) ? S_FIN : S_BRD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      sweep_q      <= '0;
      scan_q       <= '0;
      have_prev_q  <= 1'b0;
      init_build_q <= 1'b1;
      res_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      // sweep wraps to zero at the end of every init or clear pass
      if ((state_q == S_INIT) || (state_q == S_CLR)) begin
        sweep_q <= (sweep_q == LAST) ? '0 : sweep_q + PW'(1);
      end
      // a build starts its walk from the first position
      if ((accept && (gct_pkg::req_e'(req_type_i) == gct_pkg::REQ_BUILD)) ||
          ((state_q == S_INIT) && (sweep_q == LAST))) begin
        scan_q      <= '0;
        have_prev_q <= 1'b0;
      end else begin
        if (step_next && (scan_q != LAST)) begin
          scan_q <= scan_q + PW'(1);
        end
        if ((state_q == S_BCHK) && pres_rd_q) begin
          have_prev_q <= 1'b1;
        end
      end
      if (state_q == S_FIN) begin
        init_build_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // transaction capture and span datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q     <= pos_clamped;
      flag_q    <= pos_oor;
      set_rgb_q <= {red_in_i, green_in_i, blue_in_i};
    end
    case (state_q)
      S_BCHK: begin
        if (pres_rd_q && !have_prev_q) begin
          prev_q     <= scan_q;
          prev_col_q <= pcol_rd_q;
        end
        if (pres_rd_q && have_prev_q) begin
          p2_q   <= scan_q;
          c2_q   <= pcol_rd_q;
          dist_q <= scan_q - prev_q;
          wi_q   <= prev_q;
          ch_q   <= 2'd0;
        end
      end
      S_MUL: begin
        // numerator at the span start is c1 * span, stepped by c2 - c1
        num_q[ch_q]   <= NW'(chan_sel(prev_col_q, ch_q)) * NW'(dist_q);
        delta_q[ch_q] <= $signed({1'b0, chan_sel(c2_q, ch_q)}) -
                         $signed({1'b0, chan_sel(prev_col_q, ch_q)});
        ch_q          <= (ch_q == 2'd2) ? 2'd0 : ch_q + 2'd1;
      end
      S_DIVWT: begin
        if (div_done) begin
          quot_q[ch_q] <= div_quot;
          ch_q         <= (ch_q == 2'd2) ? 2'd0 : ch_q + 2'd1;
        end
      end
      S_WR: begin
        for (int k = 0; k < 3; k++) begin
          num_q[k] <= num_q[k] + NW'(delta_q[k]);
        end
        if (last_entry) begin
          prev_q     <= p2_q;
          prev_col_q <= c2_q;
        end else begin
          wi_q <= wi_q + PW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  gct_div #(
    .PosW (PW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q[ch_q]),
    .den_i   (dist_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // ---------------------------------------------------------------------------
  // memories: one write and one registered read port each
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (pres_we) begin
      pres_mem[pw_addr] <= pw_pres;
    end
    pres_rd_q <= pres_mem[scan_q];
  end

  always_ff @(posedge clk_i) begin
    if (col_we) begin
      pcol_mem[pw_addr] <= pw_col;
    end
    pcol_rd_q <= pcol_mem[scan_q];
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    tab_rd_q <= tab_mem[pos_q];
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_rgb_q    <= res_rgb_d;
    res_status_q <= res_status_d;
  end

  assign result_valid_o = res_valid_q;
  assign red_out_o      = res_rgb_q[23:16];
  assign green_out_o    = res_rgb_q[15:8];
  assign blue_out_o     = res_rgb_q[7:0];
  assign status_o       = res_status_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `GCT_ASSERT(a_res_in_idle, res_valid_q |-> (state_q == S_IDLE), "result outside idle")
  `GCT_ASSERT(a_res_single, res_valid_q |=> !res_valid_q, "result strobe held two cycles")
  `GCT_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted transaction not busy")

endmodule
